// ===== rtl/rcpls_pkg.sv =====
`default_nettype none

package rcpls_pkg;

    localparam int COORD_W = 24;
    localparam int LEN_W   = 24;
    localparam int IDX_W   = 12;
    localparam int CNT_W   = 13;
    localparam int CFG_W   = 24;

    localparam logic [2:0] CFG_CELL_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_CELL_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_STEP_LENGTH  = 3'd2;
    localparam logic [2:0] CFG_GRID_COLUMNS = 3'd3;
    localparam logic [2:0] CFG_GRID_ROWS    = 3'd4;

    localparam logic [5:0] ITERS_CELL   = 6'd25;
    localparam logic [5:0] ITERS_INTERP = 6'd48;
    localparam logic [5:0] ITERS_SQRT   = 6'd25;

    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    typedef enum logic {
        UOP_DIV,
        UOP_SQRT
    } t_uop;

    typedef enum logic [1:0] {
        KIND_SAME,
        KIND_X,
        KIND_Z,
        KIND_XZ
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL,
        ST_CELL_W,
        ST_CLASS,
        ST_LMUL,
        ST_LCLAMP,
        ST_PMUL,
        ST_IDIV,
        ST_IDIV_W,
        ST_SQA,
        ST_SQB,
        ST_SQRT,
        ST_SQRT_W,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        start;
        t_uop        op;
        logic [5:0]  iters;
        logic [49:0] num;
        logic [24:0] den;
    } t_unit_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [24:0] res;
    } t_unit_rsp;

endpackage

`default_nettype wire

// ===== rtl/ray_cell_path_length_split.sv =====
`default_nettype none

// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: point_x, point_z; tuser: ray_start
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: cell_x, cell_z, length_increment;
//           |     |                              | tuser: outside_grid; tlast: last
// i_cfg     | in  | i_cfg_wr_en                  | i_cfg_idx, i_cfg_data
//
// One word at a time through a single shift-subtract unit. A start word is only
// stored. Otherwise four cell divisions; a crossing adds an interpolation divide
// and a square root; two crossings add two of each plus two midpoint divisions.
// Reset is synchronous, active low, and restores the register defaults and
// forgets the previous point. Output stalls hold the result register; the input
// is ready again once the last result of a word sits in the output register.
module ray_cell_path_length_split (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire  [2:0]                   i_cfg_idx,
    input  wire  [rcpls_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [47:0]                  s_axis_tdata,   // point_x, point_z
    input  wire                          s_axis_tuser,   // ray_start
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [47:0]                  m_axis_tdata,   // cell_x, cell_z, length_increment
    output logic                         m_axis_tuser,   // outside_grid
    output logic                         m_axis_tlast
);
    import rcpls_pkg::*;

    // configuration
    logic [23:0] r_cw, r_ch, r_ds;
    logic [12:0] r_gc, r_gr;

    t_state r_state, n_state;
    t_kind  r_kind;

    logic        r_have;
    logic [23:0] r_x0, r_z0, r_x1, r_z1;
    logic [11:0] r_ia, r_ja, r_ib, r_jb, r_im, r_jm;
    logic        r_outa, r_outb, r_outm;
    logic [2:0]  r_cidx;
    logic        r_ax, r_dsel;
    logic [1:0]  r_k;
    logic [47:0] r_prod, r_acc;
    logic [23:0] r_den;
    logic        r_neg;
    logic [23:0] r_lx, r_lz, r_cz, r_ex;
    logic [24:0] r_dc, r_de;

    logic        r_ov;
    logic [47:0] r_odata;
    logic        r_ouser, r_olast;

    t_unit_req   w_req;
    t_unit_rsp   w_rsp;

    rcpls_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw <= 24'd256;
            r_ch <= 24'd256;
            r_ds <= 24'd256;
            r_gc <= 13'd4096;
            r_gr <= 13'd4096;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_CELL_WIDTH:   r_cw <= i_cfg_data;
                CFG_CELL_HEIGHT:  r_ch <= i_cfg_data;
                CFG_STEP_LENGTH:  r_ds <= i_cfg_data;
                CFG_GRID_COLUMNS: r_gc <= i_cfg_data[12:0];
                CFG_GRID_ROWS:    r_gr <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // cell division operands
    logic [24:0] w_cnum, w_cden;
    logic [12:0] w_ccnt;
    logic        w_cout;
    logic [11:0] w_csat;

    always_comb begin
        case (r_cidx)
            3'd0:    begin w_cnum = {1'b0, r_x1}; w_cden = {1'b0, r_cw}; w_ccnt = r_gc; end
            3'd1:    begin w_cnum = {1'b0, r_z1}; w_cden = {1'b0, r_ch}; w_ccnt = r_gr; end
            3'd2:    begin w_cnum = {1'b0, r_x0}; w_cden = {1'b0, r_cw}; w_ccnt = r_gc; end
            3'd3:    begin w_cnum = {1'b0, r_z0}; w_cden = {1'b0, r_ch}; w_ccnt = r_gr; end
            3'd4:    begin
                w_cnum = {1'b0, r_lx} + {1'b0, r_ex};
                w_cden = {r_cw, 1'b0};
                w_ccnt = r_gc;
            end
            default: begin
                w_cnum = {1'b0, r_cz} + {1'b0, r_lz};
                w_cden = {r_ch, 1'b0};
                w_ccnt = r_gr;
            end
        endcase
        w_cout = (w_cden == 25'd0) || (w_rsp.res >= {12'd0, w_ccnt});
        w_csat = ((w_cden == 25'd0) || (w_rsp.res > {13'd0, IDX_MAX})) ? IDX_MAX
                                                                      : w_rsp.res[11:0];
    end

    // line and interpolation operands, by the axis of the grid line
    logic [23:0] w_p0, w_p1, w_q0, w_q1, w_size, w_plo, w_phi, w_line, w_lcur;
    logic [11:0] w_imax;
    logic [23:0] w_aabs, w_tabs, w_dabs;
    logic        w_neg;
    logic [24:0] w_m;
    logic [25:0] w_csum;
    logic [23:0] w_cross;
    logic        w_cross_go;

    always_comb begin
        w_p0   = r_ax ? r_z0 : r_x0;
        w_p1   = r_ax ? r_z1 : r_x1;
        w_q0   = r_ax ? r_x0 : r_z0;
        w_q1   = r_ax ? r_x1 : r_z1;
        w_size = r_ax ? r_ch : r_cw;
        if (r_ax) w_imax = (r_ja > r_jb) ? r_ja : r_jb;
        else      w_imax = (r_ia > r_ib) ? r_ia : r_ib;
        w_plo  = (w_p0 < w_p1) ? w_p0 : w_p1;
        w_phi  = (w_p0 < w_p1) ? w_p1 : w_p0;
        if (r_prod < {24'd0, w_plo})      w_line = w_plo;
        else if (r_prod > {24'd0, w_phi}) w_line = w_phi;
        else                              w_line = r_prod[23:0];
        w_lcur = r_ax ? r_lz : r_lx;
        w_aabs = (w_q0 > w_q1) ? w_q0 - w_q1 : w_q1 - w_q0;
        w_tabs = (w_p1 > w_lcur) ? w_p1 - w_lcur : w_lcur - w_p1;
        w_dabs = (w_p0 > w_p1) ? w_p0 - w_p1 : w_p1 - w_p0;
        w_neg  = (w_q0 < w_q1) ^ (w_p1 < w_lcur) ^ (w_p0 < w_p1);
        w_m    = (r_den == 24'd0) ? 25'd0 : w_rsp.res;
        w_csum = r_neg ? {2'b0, w_q1} + {1'b0, w_m} : {2'b0, w_q1} - {1'b0, w_m};
        w_cross = w_csum[23:0];
        w_cross_go = ((r_state == ST_IDIV) && (r_den == 24'd0))
                  || ((r_state == ST_IDIV_W) && w_rsp.done);
    end

    // distance operands
    logic [23:0] w_px, w_pz, w_dx, w_dz;
    logic [23:0] w_ma, w_mb;
    logic [47:0] w_mul;
    logic [48:0] w_sqsum;

    always_comb begin
        w_px = r_dsel ? r_ex : r_lx;
        w_pz = r_dsel ? r_lz : r_cz;
        w_dx = (w_px > r_x0) ? w_px - r_x0 : r_x0 - w_px;
        w_dz = (w_pz > r_z0) ? w_pz - r_z0 : r_z0 - w_pz;
        case (r_state)
            ST_LMUL: begin w_ma = w_size; w_mb = {12'd0, w_imax}; end
            ST_PMUL: begin w_ma = w_aabs; w_mb = w_tabs; end
            ST_SQA:  begin w_ma = w_dx;   w_mb = w_dx; end
            ST_SQB:  begin w_ma = w_dz;   w_mb = w_dz; end
            default: begin w_ma = 24'd0;  w_mb = 24'd0; end
        endcase
        w_mul   = w_ma * w_mb;
        w_sqsum = {1'b0, r_acc} + {1'b0, r_prod};
    end

    // shared unit requests
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = UOP_DIV;
        w_req.iters = ITERS_CELL;
        w_req.num   = {w_cnum, 25'd0};
        w_req.den   = w_cden;
        case (r_state)
            ST_CELL: w_req.start = 1'b1;
            ST_IDIV: begin
                w_req.start = (r_den != 24'd0);
                w_req.iters = ITERS_INTERP;
                w_req.num   = {r_prod, 2'b00};
                w_req.den   = {1'b0, r_den};
            end
            ST_SQRT: begin
                w_req.start = 1'b1;
                w_req.op    = UOP_SQRT;
                w_req.iters = ITERS_SQRT;
                w_req.num   = {1'b0, w_sqsum};
                w_req.den   = 25'd0;
            end
            default: ;
        endcase
    end

    // result selection and saturation
    logic [24:0] w_d1, w_lo, w_hi;
    logic signed [26:0] w_len;
    logic [23:0] w_len_sat;
    logic [11:0] w_ox, w_oz;
    logic        w_oout, w_last, w_load;

    always_comb begin
        w_d1 = (r_kind == KIND_Z) ? r_de : r_dc;
        w_lo = (r_dc < r_de) ? r_dc : r_de;
        w_hi = (r_dc < r_de) ? r_de : r_dc;
        case (r_kind)
            KIND_SAME: begin
                w_len  = $signed({3'b0, r_ds});
                w_last = 1'b1;
            end
            KIND_XZ: begin
                if (r_k == 2'd0)      w_len = $signed({2'b0, w_lo});
                else if (r_k == 2'd1) w_len = $signed({3'b0, r_ds}) - $signed({2'b0, w_hi});
                else                  w_len = $signed({2'b0, w_hi}) - $signed({2'b0, w_lo});
                w_last = (r_k == 2'd2);
            end
            default: begin
                if (r_k == 2'd0) w_len = $signed({2'b0, w_d1});
                else             w_len = $signed({3'b0, r_ds}) - $signed({2'b0, w_d1});
                w_last = (r_k == 2'd1);
            end
        endcase
        if (w_len > 27'sd8388607)       w_len_sat = 24'h7FFFFF;
        else if (w_len < -27'sd8388608) w_len_sat = 24'h800000;
        else                            w_len_sat = w_len[23:0];
        case (r_k)
            2'd0:    begin w_ox = r_ia; w_oz = r_ja; w_oout = r_outa; end
            2'd1:    begin w_ox = r_ib; w_oz = r_jb; w_oout = r_outb; end
            default: begin w_ox = r_im; w_oz = r_jm; w_oout = r_outm; end
        endcase
        w_load = (r_state == ST_EMIT) && (!r_ov || m_axis_tready);
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    wire w_acc = s_axis_tvalid && s_axis_tready;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_acc && !s_axis_tuser && r_have) n_state = ST_CELL;
            ST_CELL:   n_state = ST_CELL_W;
            ST_CELL_W: if (w_rsp.done) begin
                if (r_cidx == 3'd3)      n_state = ST_CLASS;
                else if (r_cidx == 3'd5) n_state = ST_SQA;
                else                     n_state = ST_CELL;
            end
            ST_CLASS:  n_state = (r_ia == r_ib && r_ja == r_jb) ? ST_EMIT : ST_LMUL;
            ST_LMUL:   n_state = ST_LCLAMP;
            ST_LCLAMP: n_state = ST_PMUL;
            ST_PMUL:   n_state = ST_IDIV;
            ST_IDIV, ST_IDIV_W: begin
                if (r_state == ST_IDIV && r_den != 24'd0) n_state = ST_IDIV_W;
                if (w_cross_go) begin
                    if (r_kind == KIND_XZ && !r_ax) n_state = ST_LMUL;
                    else if (r_kind == KIND_XZ)     n_state = ST_CELL;
                    else                            n_state = ST_SQA;
                end
            end
            ST_SQA:    n_state = ST_SQB;
            ST_SQB:    n_state = ST_SQRT;
            ST_SQRT:   n_state = ST_SQRT_W;
            ST_SQRT_W: if (w_rsp.done)
                n_state = (r_kind == KIND_XZ && !r_dsel) ? ST_SQA : ST_EMIT;
            ST_EMIT:   if (w_load && w_last) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_cidx <= 3'd0;
            r_ax   <= 1'b0;
            r_dsel <= 1'b0;
            r_k    <= 2'd0;
            r_kind <= KIND_SAME;
        end else begin
            case (r_state)
                ST_IDLE: if (w_acc) begin
                    if (s_axis_tuser || !r_have) begin
                        r_x0   <= s_axis_tdata[23:0];
                        r_z0   <= s_axis_tdata[47:24];
                        r_have <= 1'b1;
                    end else begin
                        r_x1   <= s_axis_tdata[23:0];
                        r_z1   <= s_axis_tdata[47:24];
                        r_cidx <= 3'd0;
                        r_outa <= 1'b0;
                        r_outb <= 1'b0;
                        r_outm <= 1'b0;
                    end
                end
                ST_CELL_W: if (w_rsp.done) begin
                    case (r_cidx)
                        3'd0:    begin r_ib <= w_csat; r_outb <= r_outb | w_cout; end
                        3'd1:    begin r_jb <= w_csat; r_outb <= r_outb | w_cout; end
                        3'd2:    begin r_ia <= w_csat; r_outa <= r_outa | w_cout; end
                        3'd3:    begin r_ja <= w_csat; r_outa <= r_outa | w_cout; end
                        3'd4:    begin r_im <= w_csat; r_outm <= r_outm | w_cout; end
                        default: begin r_jm <= w_csat; r_outm <= r_outm | w_cout; end
                    endcase
                    r_cidx <= r_cidx + 3'd1;
                    r_dsel <= 1'b0;
                end
                ST_CLASS: begin
                    r_k <= 2'd0;
                    if (r_ia == r_ib && r_ja == r_jb) begin
                        r_kind <= KIND_SAME;
                    end else if (r_ia == r_ib) begin
                        r_kind <= KIND_Z;
                        r_ax   <= 1'b1;
                        r_dsel <= 1'b1;
                    end else if (r_ja == r_jb) begin
                        r_kind <= KIND_X;
                        r_ax   <= 1'b0;
                        r_dsel <= 1'b0;
                    end else begin
                        r_kind <= KIND_XZ;
                        r_ax   <= 1'b0;
                        r_dsel <= 1'b0;
                    end
                end
                ST_LMUL:   r_prod <= w_mul;
                ST_LCLAMP: if (r_ax) r_lz <= w_line; else r_lx <= w_line;
                ST_PMUL: begin
                    r_prod <= w_mul;
                    r_den  <= w_dabs;
                    r_neg  <= w_neg;
                end
                ST_IDIV, ST_IDIV_W: if (w_cross_go) begin
                    if (r_ax) r_ex <= w_cross; else r_cz <= w_cross;
                    if (r_kind == KIND_XZ && !r_ax) r_ax   <= 1'b1;
                    else if (r_kind == KIND_XZ)     r_cidx <= 3'd4;
                end
                ST_SQA: r_prod <= w_mul;
                ST_SQB: begin
                    r_acc  <= r_prod;
                    r_prod <= w_mul;
                end
                ST_SQRT_W: if (w_rsp.done) begin
                    if (r_dsel) r_de <= w_rsp.res; else r_dc <= w_rsp.res;
                    r_dsel <= 1'b1;
                end
                ST_EMIT: if (w_load) begin
                    r_k <= r_k + 2'd1;
                    if (w_last) begin
                        // advance the previous point
                        r_x0 <= r_x1;
                        r_z0 <= r_z1;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register: hold while stalled, load the next word when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (w_load)             r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
            if (w_load) begin
                r_odata <= {w_len_sat, w_oz, w_ox};
                r_ouser <= w_oout;
                r_olast <= w_last;
            end
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    // the shared unit is never restarted mid-operation
    a_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("shared unit started while busy");

    // no input is taken while the unit is at work
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_rsp.busy)
        else $error("input ready while unit busy");

    // the last word of a point returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == ST_IDLE && m_axis_tlast))
        else $error("sequencer not idle after last word");

    // at most three words per point
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_k != 2'd3))
        else $error("result counter overrun");

endmodule

`default_nettype wire

// ===== rtl/rcpls_unit.sv =====
`default_nettype none

// Shared shift-subtract unit: restoring divide (one bit a cycle) or
// restoring square root (one root bit a cycle) on a common subtractor.
module rcpls_unit (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  rcpls_pkg::t_unit_req  i_req,
    output rcpls_pkg::t_unit_rsp  o_rsp
);
    import rcpls_pkg::*;

    t_uop        r_op;
    logic [5:0]  r_cnt;
    logic [27:0] r_rem;
    logic [24:0] r_root;
    logic [49:0] r_sh;
    logic [24:0] r_den;
    logic        r_done;

    logic [29:0] w_a;
    logic [29:0] w_b;
    logic [30:0] w_diff;
    logic        w_ge;

    always_comb begin
        if (r_op == UOP_DIV) begin
            w_a = {1'b0, r_rem, r_sh[49]};
            w_b = {5'b0, r_den};
        end else begin
            w_a = {r_rem, r_sh[49:48]};
            w_b = {3'b0, r_root, 2'b01};
        end
        w_diff = {1'b0, w_a} - {1'b0, w_b};
        w_ge   = ~w_diff[30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 6'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (i_req.start) begin
                r_op   <= i_req.op;
                r_cnt  <= i_req.iters;
                r_rem  <= 28'd0;
                r_root <= 25'd0;
                r_sh   <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_cnt != 6'd0) begin
                r_cnt  <= r_cnt - 6'd1;
                r_rem  <= w_ge ? w_diff[27:0] : w_a[27:0];
                r_root <= {r_root[23:0], w_ge};
                r_sh   <= (r_op == UOP_DIV) ? {r_sh[48:0], 1'b0} : {r_sh[47:0], 2'b00};
            end
        end
    end

    assign o_rsp.busy = (r_cnt != 6'd0);
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_root;

endmodule

`default_nettype wire
